// ===== sv/wsat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsat_pkg
// Shared constants, types and rounding helpers of the wheel speed and
// acceleration telemetry unit.
// ----------------------------------------------------------------------------
package wsat_pkg;

    // record period and fixed-point scale factors
    localparam int unsigned PERIOD_MS   = 20;
    localparam int unsigned HALF_PERIOD = PERIOD_MS / 2;
    localparam int unsigned MS_PER_S    = 1000;
    localparam int unsigned SPEED_K     = 1784358;  // 8 * 65 * pi / 60 in Q16
    localparam int unsigned ALPHA_Q16   = 13107;    // 0.2 in Q16

    // floor((2^32 - 1) / period): quotient estimate is low by at most one
    localparam logic [31:0] DIV_RECIP = 32'(64'd4294967295 / 64'(PERIOD_MS));

    localparam int MUL_W = 33;
    localparam int SPD_W = 22;
    localparam int SUM_W = 17;

    typedef logic signed [MUL_W-1:0]   mul_op_t;
    typedef logic signed [2*MUL_W-1:0] mul_prod_t;
    typedef logic signed [SPD_W-1:0]   speed_t;
    typedef logic signed [SUM_W-1:0]   wsum_t;

    typedef enum logic [1:0] {
        PHASE_STOPPED  = 2'd0,
        PHASE_STRAIGHT = 2'd1,
        PHASE_TURNING  = 2'd2
    } phase_t;

    // each product state issues one product, which the state after it takes
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TK,
        ST_MK,
        ST_DREC,
        ST_T1K,
        ST_DQP,
        ST_M1K,
        ST_TREC,
        ST_MREC,
        ST_TQP,
        ST_MQP,
        ST_FWAIT,
        ST_FILT,
        ST_FDONE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        state_t state;
        logic   in_ready;
        logic   out_load;
    } ctrl_t;

    // v / 2^16, round half away from zero
    function automatic logic signed [32:0] shr16_rnd(input logic signed [47:0] v);
        logic        neg;
        logic [47:0] mag;
        logic [47:0] m;
        begin
            neg = v[47];
            mag = neg ? 48'(-v) : 48'(v);
            m   = (mag + 48'd32768) >> 16;
            return neg ? 33'(-m) : 33'(m);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        begin
            if (v > 34'sd2147483647)
                return 32'h7fffffff;
            else if (v < -34'sd2147483648)
                return 32'h80000000;
            else
                return 32'(v);
        end
    endfunction

    // sign and magnitude to int32 with saturation
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [32:0] mag);
        begin
            if (neg)
                return (mag > 33'h080000000) ? 32'h80000000 : 32'(-mag);
            else
                return (mag > 33'h07fffffff) ? 32'h7fffffff : 32'(mag);
        end
    endfunction

    // q.8 value to rounded, saturated int16
    function automatic logic signed [15:0] out16(input logic signed [31:0] q8);
        logic        neg;
        logic [32:0] mag;
        logic [32:0] m;
        begin
            neg = q8[31];
            mag = neg ? 33'(-(33'(q8))) : 33'(q8);
            m   = (mag + 33'd128) >> 8;
            if (neg)
                return (m > 33'd32768) ? 16'sh8000 : 16'(-m);
            else
                return (m > 33'd32767) ? 16'sh7fff : 16'(m);
        end
    endfunction

endpackage

// ===== sv/wheel_speed_accel_telemetry_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_accel_telemetry_unit
// Periodic speed and acceleration record from wheel rpm polls.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid / in_ready | now_ms, wheel target and measured rpm, status
//  out      | out_valid/out_ready | sequence, stamp, phase, speeds, accels, flags
//
//  a poll before the deadline is taken in the idle state and gives no record
//  a poll that gives a record runs through accept, 11 products on the one
//  shared 33x33 multiplier, two waits around the filter product, and the load
//  in_ready is high only while the sequencer is idle
//  a record waits in the output register; a stalled output holds the
//  sequencer in its last step until the register frees
//  reset clears all history; no clearing pass
// ----------------------------------------------------------------------------
module wheel_speed_accel_telemetry_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        now_ms,
    input  logic signed [15:0] left_target_rpm,
    input  logic signed [15:0] right_target_rpm,
    input  logic signed [15:0] left_measured_rpm,
    input  logic signed [15:0] right_measured_rpm,
    input  logic               running,
    input  logic               turning,
    input  logic               line_detected,
    input  logic               finished,
    input  logic               emergency_stop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         sequence_res,
    output logic [31:0]        stamp_ms,
    output logic [1:0]         drive_phase,
    output logic signed [15:0] speed_target_mm_s,
    output logic signed [15:0] speed_measured_mm_s,
    output logic signed [15:0] accel_target_mm_s2,
    output logic signed [15:0] accel_measured_mm_s2,
    output logic [5:0]         status_flags
);
    import wsat_pkg::*;

    ctrl_t     ctrl;
    logic      out_free;
    logic      emit;
    logic      in_xfer;
    logic [31:0] deadline_eff;
    logic [31:0] d_full;

    // history
    logic        started_reg;
    logic [31:0] deadline_reg;
    logic [7:0]  count_reg;
    logic        have_prev_reg;
    logic        was_running_reg;
    speed_t      prev_t_reg;
    speed_t      prev_m_reg;
    logic signed [31:0] f_reg;

    // captured poll
    logic [31:0] now_reg;
    logic        run_reg;
    logic        turn_reg;
    logic        line_reg;
    logic        fin_reg;
    logic        estop_reg;
    wsum_t       tsum_reg;
    wsum_t       msum_reg;
    logic [30:0] d_reg;

    // work registers
    speed_t      tspd_reg;
    speed_t      mspd_reg;
    logic        tneg_reg;
    logic        mneg_reg;
    logic [30:0] dq_reg;
    logic [31:0] tm_reg;
    logic [31:0] mm_reg;
    logic [31:0] tq_reg;
    logic [31:0] mq_reg;
    logic signed [31:0] traw_reg;
    logic signed [31:0] mraw_reg;
    logic        acc_valid_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  sequence_res_reg;
    logic [31:0] stamp_ms_reg;
    phase_t      drive_phase_reg;
    logic signed [15:0] speed_target_reg;
    logic signed [15:0] speed_measured_reg;
    logic signed [15:0] accel_target_reg;
    logic signed [15:0] accel_measured_reg;
    logic [5:0]  status_flags_reg;

    // shared multiplier
    mul_op_t   mul_a;
    mul_op_t   mul_b;
    mul_prod_t prod_reg;

    // datapath around the product
    logic signed [22:0] dt_spd;
    logic [21:0]        dt_mag;
    logic signed [32:0] rnd_val;
    logic [31:0]        r_d;
    logic [31:0]        r_d_fix;
    logic [31:0]        deadline_new;
    logic [31:0]        acc_m;
    logic [31:0]        acc_q;
    logic               acc_neg;
    logic [31:0]        r_a;
    logic [32:0]        q_fix;
    logic signed [31:0] raw_acc;
    logic signed [32:0] f_diff;
    logic signed [33:0] f_sum;
    logic signed [31:0] f_new;

    assign in_ready = ctrl.in_ready;
    assign in_xfer  = in_valid && ctrl.in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign deadline_eff = started_reg ? deadline_reg : now_ms;
    assign d_full       = now_ms - deadline_eff;
    assign emit         = !d_full[31];

    wsat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .emit     (emit),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    wsat_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    // speed difference against the previous record
    always_comb
    begin
        if (ctrl.state == ST_T1K)
            dt_spd = 23'(tspd_reg) - 23'(prev_t_reg);
        else
            dt_spd = 23'(mspd_reg) - 23'(prev_m_reg);
        dt_mag = dt_spd[22] ? 22'(-dt_spd) : 22'(dt_spd);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.state)
            ST_TK:
            begin
                mul_a = mul_op_t'(tsum_reg);
                mul_b = mul_op_t'(SPEED_K);
            end
            ST_MK:
            begin
                mul_a = mul_op_t'(msum_reg);
                mul_b = mul_op_t'(SPEED_K);
            end
            ST_DREC:
            begin
                mul_a = mul_op_t'({1'b0, d_reg});
                mul_b = mul_op_t'({1'b0, DIV_RECIP});
            end
            ST_T1K, ST_M1K:
            begin
                mul_a = mul_op_t'({1'b0, dt_mag});
                mul_b = mul_op_t'(MS_PER_S);
            end
            ST_DQP:
            begin
                mul_a = mul_op_t'({1'b0, dq_reg});
                mul_b = mul_op_t'(PERIOD_MS);
            end
            ST_TREC:
            begin
                mul_a = mul_op_t'({1'b0, tm_reg});
                mul_b = mul_op_t'({1'b0, DIV_RECIP});
            end
            ST_MREC:
            begin
                mul_a = mul_op_t'({1'b0, mm_reg});
                mul_b = mul_op_t'({1'b0, DIV_RECIP});
            end
            ST_TQP:
            begin
                mul_a = mul_op_t'({1'b0, tq_reg});
                mul_b = mul_op_t'(PERIOD_MS);
            end
            ST_MQP:
            begin
                mul_a = mul_op_t'({1'b0, mq_reg});
                mul_b = mul_op_t'(PERIOD_MS);
            end
            ST_FILT:
            begin
                mul_a = f_diff;
                mul_b = mul_op_t'(ALPHA_Q16);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        rnd_val = shr16_rnd(prod_reg[47:0]);

        // remainder of the deadline gap, one correction step
        r_d          = {1'b0, d_reg} - prod_reg[31:0];
        r_d_fix      = (r_d >= 32'(PERIOD_MS)) ? r_d - 32'(PERIOD_MS) : r_d;
        deadline_new = now_reg + 32'(PERIOD_MS) - r_d_fix;

        // rounded quotient of the scaled speed step, one correction step
        if (ctrl.state == ST_MQP)
        begin
            acc_m   = tm_reg;
            acc_q   = tq_reg;
            acc_neg = tneg_reg;
        end
        else
        begin
            acc_m   = mm_reg;
            acc_q   = mq_reg;
            acc_neg = mneg_reg;
        end
        r_a     = acc_m - prod_reg[31:0];
        q_fix   = {1'b0, acc_q} + 33'(r_a >= 32'(PERIOD_MS));
        raw_acc = sat_mag(acc_neg, q_fix);

        f_diff = 33'(mraw_reg) - 33'(f_reg);
        f_sum  = 34'(f_reg) + 34'(rnd_val);
        f_new  = sat32(f_sum);
    end

    // history and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            deadline_reg    <= '0;
            count_reg       <= '0;
            have_prev_reg   <= 1'b0;
            was_running_reg <= 1'b0;
            prev_t_reg      <= '0;
            prev_m_reg      <= '0;
            f_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                started_reg <= 1'b1;
                if (!started_reg)
                    deadline_reg <= now_ms;
                // filter history restarts when running starts
                if (emit && running && !was_running_reg)
                begin
                    have_prev_reg <= 1'b0;
                    f_reg         <= '0;
                end
            end
            if (ctrl.state == ST_M1K)
                deadline_reg <= deadline_new;
            if (ctrl.state == ST_FDONE)
                f_reg <= have_prev_reg ? f_new : '0;
            if (ctrl.out_load)
            begin
                prev_t_reg      <= tspd_reg;
                prev_m_reg      <= mspd_reg;
                was_running_reg <= run_reg;
                have_prev_reg   <= 1'b1;
                count_reg       <= count_reg + 8'd1;
            end
            if (ctrl.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // poll capture and work registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            now_reg   <= now_ms;
            run_reg   <= running;
            turn_reg  <= turning;
            line_reg  <= line_detected;
            fin_reg   <= finished;
            estop_reg <= emergency_stop;
            tsum_reg  <= running ? wsum_t'(left_target_rpm) + wsum_t'(right_target_rpm) : '0;
            msum_reg  <= wsum_t'(left_measured_rpm) + wsum_t'(right_measured_rpm);
            d_reg     <= d_full[30:0];
        end
        case (ctrl.state)
            ST_MK:    tspd_reg <= speed_t'(rnd_val);
            ST_DREC:  mspd_reg <= speed_t'(rnd_val);
            ST_T1K:
            begin
                dq_reg   <= prod_reg[62:32];
                tneg_reg <= dt_spd[22];
            end
            ST_DQP:   tm_reg <= prod_reg[31:0] + 32'(HALF_PERIOD);
            ST_M1K:   mneg_reg <= dt_spd[22];
            ST_TREC:  mm_reg <= prod_reg[31:0] + 32'(HALF_PERIOD);
            ST_MREC:  tq_reg <= prod_reg[63:32];
            ST_TQP:   mq_reg <= prod_reg[63:32];
            ST_MQP:   traw_reg <= raw_acc;
            ST_FWAIT: mraw_reg <= raw_acc;
            ST_FDONE: acc_valid_reg <= have_prev_reg;
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            sequence_res_reg   <= count_reg;
            stamp_ms_reg       <= now_reg;
            drive_phase_reg    <= !run_reg ? PHASE_STOPPED :
                                  (turn_reg ? PHASE_TURNING : PHASE_STRAIGHT);
            speed_target_reg   <= out16(32'(tspd_reg));
            speed_measured_reg <= out16(32'(mspd_reg));
            accel_target_reg   <= acc_valid_reg ? out16(traw_reg) : '0;
            accel_measured_reg <= acc_valid_reg ? out16(f_reg) : '0;
            status_flags_reg   <= {acc_valid_reg, estop_reg, fin_reg,
                                   line_reg && run_reg, run_reg, 1'b1};
        end
    end

    assign out_valid            = out_valid_reg;
    assign sequence_res         = sequence_res_reg;
    assign stamp_ms             = stamp_ms_reg;
    assign drive_phase          = drive_phase_reg;
    assign speed_target_mm_s    = speed_target_reg;
    assign speed_measured_mm_s  = speed_measured_reg;
    assign accel_target_mm_s2   = accel_target_reg;
    assign accel_measured_mm_s2 = accel_measured_reg;
    assign status_flags         = status_flags_reg;

    // a poll at or past the deadline starts the product sequence
    a_emit_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && emit) |=> (ctrl.state == ST_TK))
        else $error("record poll did not start the sequence");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |=> out_valid)
        else $error("loaded record not presented");

    // the advanced deadline lies within one period past the poll time
    a_deadline_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.state == ST_M1K) |=>
        ((deadline_reg - now_reg) != 32'd0 && (deadline_reg - now_reg) <= 32'(PERIOD_MS)))
        else $error("deadline not advanced past poll time");

    a_invalid_accel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !status_flags[5]) |->
        (accel_target_mm_s2 == 16'sd0 && accel_measured_mm_s2 == 16'sd0 && status_flags[0]))
        else $error("invalid acceleration not zero");

endmodule

// ===== sv/wsat_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsat_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wsat_mul (
    input  logic                clk,
    input  wsat_pkg::mul_op_t   a,
    input  wsat_pkg::mul_op_t   b,
    output wsat_pkg::mul_prod_t prod_reg
);
    import wsat_pkg::*;

    mul_prod_t prod_next;

    assign prod_next = mul_prod_t'(a) * mul_prod_t'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ===== sv/wsat_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsat_ctrl
// Sequencer that walks one record through the shared multiplier.
// ----------------------------------------------------------------------------
module wsat_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            emit,
    input  logic            out_free,
    output wsat_pkg::ctrl_t ctrl
);
    import wsat_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        ctrl.state    = state_reg;
        ctrl.in_ready = 1'b0;
        ctrl.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                // a poll before the deadline is taken and dropped
                if (in_valid && emit)
                    state_next = ST_TK;
            end
            ST_TK:    state_next = ST_MK;
            ST_MK:    state_next = ST_DREC;
            ST_DREC:  state_next = ST_T1K;
            ST_T1K:   state_next = ST_DQP;
            ST_DQP:   state_next = ST_M1K;
            ST_M1K:   state_next = ST_TREC;
            ST_TREC:  state_next = ST_MREC;
            ST_MREC:  state_next = ST_TQP;
            ST_TQP:   state_next = ST_MQP;
            ST_MQP:   state_next = ST_FWAIT;
            ST_FWAIT: state_next = ST_FILT;
            ST_FILT:  state_next = ST_FDONE;
            ST_FDONE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

endmodule
